/* rtl/stable_value_change_detector_assert.svh */
// ---------------------------------------------------------------------------
// Stable value change detector assertion macros
// Checks for the block, each written as a single line per use.
// ---------------------------------------------------------------------------
`ifndef STABLE_VALUE_CHANGE_DETECTOR_ASSERT_SVH
`define STABLE_VALUE_CHANGE_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVCD_ASSERT_SAME(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVCD_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/svcd_pkg.sv */
// ---------------------------------------------------------------------------
// Stable value change detector package
// Widths, constants, register indexes and item types of the block.
// ---------------------------------------------------------------------------
package svcd_pkg;

  localparam int SEQ_BITS     = 32;
  localparam int COUNT_BITS   = 16;
  localparam int STABLE_BITS  = 10;
  localparam int VALUE_BITS   = 8;
  localparam int RAW_BITS     = 16;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [STABLE_BITS-1:0] STABLE_DEFAULT = STABLE_BITS'(15);
  localparam logic [STABLE_BITS-1:0] STABLE_CAP     = STABLE_BITS'(600);
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX      = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  REPORTS_RESET  = {COUNT_BITS{1'b1}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_STABLE_FRAMES = 1'b0,
    CFG_MAX_REPORTS       = 1'b1
  } cfg_index_t;

  typedef enum logic {
    REQ_SNAPSHOT = 1'b0,
    REQ_RESTART  = 1'b1
  } req_type_t;

  typedef struct packed {
    logic                       req_type;
    logic                       observer_ok;
    logic                       source_ready;
    logic                       mode_known;
    logic                       mode_active;
    logic                       value_known;
    logic signed [RAW_BITS-1:0] raw_value;
    logic [SEQ_BITS-1:0]        seq_num;
  } snap_t;

  typedef struct packed {
    logic                   report_valid;
    logic [COUNT_BITS-1:0]  report_ordinal;
    logic [SEQ_BITS-1:0]    report_seq;
    logic [VALUE_BITS-1:0]  report_value;
    logic [STABLE_BITS-1:0] report_stable;
    logic [COUNT_BITS-1:0]  report_count;
  } rpt_t;

endpackage

/* rtl/svcd_snap_if.sv */
// ---------------------------------------------------------------------------
// Snapshot channel
// Valid/ready channel that carries snapshot and restart items.
// ---------------------------------------------------------------------------
interface svcd_snap_if;
  import svcd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic                       observer_ok;
  logic                       source_ready;
  logic                       mode_known;
  logic                       mode_active;
  logic                       value_known;
  logic signed [RAW_BITS-1:0] raw_value;
  logic [SEQ_BITS-1:0]        seq_num;

  modport source (
    output valid, req_type, observer_ok, source_ready, mode_known, mode_active,
           value_known, raw_value, seq_num,
    input  ready
  );

  modport sink (
    input  valid, req_type, observer_ok, source_ready, mode_known, mode_active,
           value_known, raw_value, seq_num,
    output ready
  );
endinterface

/* rtl/svcd_rpt_if.sv */
// ---------------------------------------------------------------------------
// Report channel
// Valid/ready channel that carries one result per accepted item.
// ---------------------------------------------------------------------------
interface svcd_rpt_if;
  import svcd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   report_valid;
  logic [COUNT_BITS-1:0]  report_ordinal;
  logic [SEQ_BITS-1:0]    report_seq;
  logic [VALUE_BITS-1:0]  report_value;
  logic [STABLE_BITS-1:0] report_stable;
  logic [COUNT_BITS-1:0]  report_count;

  modport source (
    output valid, report_valid, report_ordinal, report_seq, report_value,
           report_stable, report_count,
    input  ready
  );

  modport sink (
    input  valid, report_valid, report_ordinal, report_seq, report_value,
           report_stable, report_count,
    output ready
  );
endinterface

/* rtl/stable_value_change_detector.sv */
// ---------------------------------------------------------------------------
// Stable value change detector
// Debounces a sampled byte value and reports each new stable value once.
// ---------------------------------------------------------------------------
// Items enter on the snap channel and one result per item leaves on the rpt
// channel; both use a valid/ready transaction. A snapshot passes only with
// all its flags set, a value within 0 to 255 and a rising sequence number.
// A value must repeat for the configured number of snapshots before it is
// reported, and each change is reported once until the report limit.
// The item is held in an input register, evaluated in combinational logic
// and written to the result register. The block takes one transaction per
// cycle when rpt.ready holds, set by the single state update per cycle.
// When the receiver stalls, the result register holds and the input
// register fills, after which snap.ready drops until rpt.ready returns.
// Reset clears all session state and sets min_stable_frames to 15 and
// max_reports to 65535. A restart item clears the session state only.
// Registers are written through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while the block is idle, which it does not enforce.
// ---------------------------------------------------------------------------
module stable_value_change_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [svcd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [svcd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  svcd_snap_if.sink                            snap,
  svcd_rpt_if.source                           rpt
);
  import svcd_pkg::*;

  logic [STABLE_BITS-1:0] min_stable_frames;
  logic [COUNT_BITS-1:0]  max_reports;

  logic                   seq_seen;
  logic [SEQ_BITS-1:0]    last_seq;
  logic                   cand_valid;
  logic [VALUE_BITS-1:0]  cand_value;
  logic [STABLE_BITS-1:0] repeat_count;
  logic                   emitted_valid;
  logic [VALUE_BITS-1:0]  emitted_value;
  logic [COUNT_BITS-1:0]  emit_count;
  logic [COUNT_BITS-1:0]  next_ordinal;

  logic                   s1_valid;
  snap_t                  s1;
  logic                   out_valid;
  rpt_t                   out_reg;

  logic                   advance;
  logic                   restart;
  logic                   accept_snap;
  logic [VALUE_BITS-1:0]  value8;
  logic [STABLE_BITS-1:0] threshold;
  logic [STABLE_BITS-1:0] repeat_count_next;
  logic                   fire;
  logic [COUNT_BITS-1:0]  emit_count_next;
  rpt_t                   out_next;

  assign advance   = s1_valid && (!out_valid || rpt.ready);
  assign snap.ready = !s1_valid || advance;
  assign restart   = (s1.req_type == REQ_RESTART);
  assign value8    = s1.raw_value[VALUE_BITS-1:0];

  always_comb begin
    if (min_stable_frames == '0) begin
      threshold = STABLE_DEFAULT;
    end else if (min_stable_frames > STABLE_CAP) begin
      threshold = STABLE_CAP;
    end else begin
      threshold = min_stable_frames;
    end
  end

  always_comb begin
    accept_snap = !restart && s1.observer_ok && s1.source_ready && s1.mode_known &&
                  s1.mode_active && s1.value_known &&
                  (s1.raw_value[RAW_BITS-1:VALUE_BITS] == '0) && (max_reports != '0) &&
                  !(seq_seen && (s1.seq_num <= last_seq));

    if (!cand_valid || (cand_value != value8)) begin
      repeat_count_next = STABLE_BITS'(1);
    end else if (repeat_count < threshold) begin
      repeat_count_next = repeat_count + STABLE_BITS'(1);
    end else begin
      repeat_count_next = repeat_count;
    end

    fire = accept_snap && (repeat_count_next >= threshold) &&
           !(emitted_valid && (emitted_value == value8)) &&
           (emit_count < max_reports) && (emit_count != COUNT_MAX);

    emit_count_next = fire ? emit_count + COUNT_BITS'(1) : emit_count;

    out_next = '0;
    if (fire) begin
      out_next.report_valid   = 1'b1;
      out_next.report_ordinal = next_ordinal;
      out_next.report_seq     = s1.seq_num;
      out_next.report_value   = value8;
      out_next.report_stable  = repeat_count_next;
    end
    out_next.report_count = restart ? '0 : emit_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_stable_frames <= STABLE_DEFAULT;
      max_reports       <= REPORTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MIN_STABLE_FRAMES: min_stable_frames <= cfg_wdata[STABLE_BITS-1:0];
        CFG_MAX_REPORTS:       max_reports       <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && restart)) begin
      seq_seen      <= 1'b0;
      last_seq      <= '0;
      cand_valid    <= 1'b0;
      cand_value    <= '0;
      repeat_count  <= '0;
      emitted_valid <= 1'b0;
      emitted_value <= '0;
      emit_count    <= '0;
      next_ordinal  <= COUNT_BITS'(1);
    end else if (advance && accept_snap) begin
      seq_seen     <= 1'b1;
      last_seq     <= s1.seq_num;
      cand_valid   <= 1'b1;
      cand_value   <= value8;
      repeat_count <= repeat_count_next;
      emit_count   <= emit_count_next;
      if (fire) begin
        emitted_valid <= 1'b1;
        emitted_value <= value8;
        if (next_ordinal != COUNT_MAX) begin
          next_ordinal <= next_ordinal + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (snap.valid && snap.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rpt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap.valid && snap.ready) begin
      s1.req_type     <= snap.req_type;
      s1.observer_ok  <= snap.observer_ok;
      s1.source_ready <= snap.source_ready;
      s1.mode_known   <= snap.mode_known;
      s1.mode_active  <= snap.mode_active;
      s1.value_known  <= snap.value_known;
      s1.raw_value    <= snap.raw_value;
      s1.seq_num      <= snap.seq_num;
    end
    if (advance) begin
      out_reg <= out_next;
    end
  end

  assign rpt.valid          = out_valid;
  assign rpt.report_valid   = out_reg.report_valid;
  assign rpt.report_ordinal = out_reg.report_ordinal;
  assign rpt.report_seq     = out_reg.report_seq;
  assign rpt.report_value   = out_reg.report_value;
  assign rpt.report_stable  = out_reg.report_stable;
  assign rpt.report_count   = out_reg.report_count;

`include "stable_value_change_detector_assert.svh"

  `SVCD_ASSERT_SAME(a_ordinal_matches_count, clk, rst,
                    rpt.valid && rpt.report_valid,
                    rpt.report_ordinal == rpt.report_count,
                    "report ordinal differs from report count")
  `SVCD_ASSERT_SAME(a_report_marks_emitted, clk, rst,
                    rpt.valid && rpt.report_valid,
                    emitted_valid && (emitted_value == rpt.report_value),
                    "shown report not recorded as emitted")
  `SVCD_ASSERT_SAME(a_candidate_count, clk, rst,
                    1'b1,
                    cand_valid == (repeat_count != '0),
                    "candidate flag and repeat count disagree")
  `SVCD_ASSERT_NEXT(a_restart_clears, clk, rst,
                    advance && restart,
                    (emit_count == '0) && !cand_valid && !seq_seen,
                    "restart left session state behind")

endmodule

/* test/svcd_report_monitor.sv */
// ----------------------------------------------------------------------------
// Stable value change detector report monitor
// Watches the snapshot and report channels and the register write port. It
// predicts one report per accepted transaction from its own copy of the
// debounce state and compares each returned report with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module svcd_report_monitor
  import svcd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  svcd_snap_if                     snap,
  svcd_rpt_if                      rpt,
  output int unsigned              mismatches,
  output int unsigned              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [STABLE_BITS-1:0] min_stable;
  logic [COUNT_BITS-1:0]  max_reports;

  bit                     seq_seen;
  logic [SEQ_BITS-1:0]    last_seq;
  bit                     cand_valid;
  logic [VALUE_BITS-1:0]  cand_value;
  logic [STABLE_BITS-1:0] repeat_cnt;
  bit                     emitted_valid;
  logic [VALUE_BITS-1:0]  emitted_value;
  logic [COUNT_BITS-1:0]  emit_cnt;
  logic [COUNT_BITS-1:0]  next_ordinal;

  rpt_t expected_reports[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task automatic clear_session();
    seq_seen = 1'b0;
    last_seq = '0;
    cand_valid = 1'b0;
    cand_value = '0;
    repeat_cnt = '0;
    emitted_valid = 1'b0;
    emitted_value = '0;
    emit_cnt = '0;
    next_ordinal = COUNT_BITS'(1);
  endtask

  task automatic predict_report(input snap_t s, output rpt_t r);
    logic [STABLE_BITS-1:0] thr;
    logic [VALUE_BITS-1:0]  v;
    logic                   ok;
    r = '0;
    if (s.req_type == REQ_RESTART) begin
      clear_session();
    end else begin
      v = s.raw_value[VALUE_BITS-1:0];
      ok = s.observer_ok && s.source_ready && s.mode_known && s.mode_active &&
           s.value_known && (s.raw_value[RAW_BITS-1:VALUE_BITS] == '0) &&
           (max_reports != '0) && !(seq_seen && s.seq_num <= last_seq);
      if (ok) begin
        seq_seen = 1'b1;
        last_seq = s.seq_num;
        if (min_stable == '0)
          thr = STABLE_DEFAULT;
        else if (min_stable > STABLE_CAP)
          thr = STABLE_CAP;
        else
          thr = min_stable;
        if (!cand_valid || cand_value != v) begin
          cand_valid = 1'b1;
          cand_value = v;
          repeat_cnt = STABLE_BITS'(1);
        end else if (repeat_cnt < thr) begin
          repeat_cnt = repeat_cnt + STABLE_BITS'(1);
        end
        if (repeat_cnt >= thr && !(emitted_valid && emitted_value == v) &&
            emit_cnt < max_reports && emit_cnt < COUNT_MAX) begin
          r.report_valid = 1'b1;
          r.report_ordinal = next_ordinal;
          r.report_seq = s.seq_num;
          r.report_value = v;
          r.report_stable = repeat_cnt;
          if (next_ordinal < COUNT_MAX)
            next_ordinal = next_ordinal + COUNT_BITS'(1);
          emit_cnt = emit_cnt + COUNT_BITS'(1);
          emitted_valid = 1'b1;
          emitted_value = v;
        end
      end
    end
    r.report_count = emit_cnt;
  endtask

  function automatic string fmt_report(input rpt_t r);
    return $sformatf("v=%0d ord=%0d seq=%0h val=%0d stable=%0d cnt=%0d",
                     r.report_valid, r.report_ordinal, r.report_seq,
                     r.report_value, r.report_stable, r.report_count);
  endfunction

  task automatic note_mismatch(input string what, input rpt_t want, input rpt_t got);
    if (mismatches < 10)
      $display("%0t %s: expected %s, got %s", $time, what,
               fmt_report(want), fmt_report(got));
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    snap_t s;
    rpt_t  want;
    rpt_t  got;
    if (rst) begin
      min_stable = STABLE_DEFAULT;
      max_reports = REPORTS_RESET;
      clear_session();
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_STABLE_FRAMES: min_stable = cfg_wdata[STABLE_BITS-1:0];
          CFG_MAX_REPORTS:       max_reports = cfg_wdata[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (snap.valid && snap.ready) begin
        s.req_type = snap.req_type;
        s.observer_ok = snap.observer_ok;
        s.source_ready = snap.source_ready;
        s.mode_known = snap.mode_known;
        s.mode_active = snap.mode_active;
        s.value_known = snap.value_known;
        s.raw_value = snap.raw_value;
        s.seq_num = snap.seq_num;
        predict_report(s, want);
        expected_reports.insert(expected_reports.size(), want);
      end
      if (rpt.valid && rpt.ready) begin
        got.report_valid = rpt.report_valid;
        got.report_ordinal = rpt.report_ordinal;
        got.report_seq = rpt.report_seq;
        got.report_value = rpt.report_value;
        got.report_stable = rpt.report_stable;
        got.report_count = rpt.report_count;
        if (expected_reports.size() == 0) begin
          note_mismatch("unexpected report", '0, got);
        end else begin
          want = expected_reports.pop_front();
          if (got.report_valid !== want.report_valid ||
              got.report_ordinal !== want.report_ordinal ||
              got.report_seq !== want.report_seq ||
              got.report_value !== want.report_value ||
              got.report_stable !== want.report_stable ||
              got.report_count !== want.report_count)
            note_mismatch("report mismatch", want, got);
        end
      end
    end
    pending = expected_reports.size();
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Stable value change detector testbench
// Drives snapshot and restart transactions with random idle and stall bursts,
// writes the registers between phases, and leaves prediction and checking to
// the report monitor. Directed items cover field extremes, rejection cases
// and a lowered threshold, followed by random debounce sequences, a capped
// threshold run and a final random run without idle cycles or stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svcd_pkg::*;

  localparam logic [4:0] ALL_FLAGS = 5'h1F;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  int unsigned              mismatch_count;
  int unsigned              pending_count;
  bit                       idle_on;
  bit                       stall_on;
  longint unsigned          seq_used;

  svcd_snap_if snap_ch();
  svcd_rpt_if  rpt_ch();

  stable_value_change_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .snap      (snap_ch),
    .rpt       (rpt_ch)
  );

  svcd_report_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .snap       (snap_ch),
    .rpt        (rpt_ch),
    .mismatches (mismatch_count),
    .pending    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rpt_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 15) == 0) begin
        rpt_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      rpt_ch.ready <= 1'b1;
    end
  end

  function automatic snap_t make_snap(input logic [4:0] flags, input logic [15:0] raw,
                                      input logic [31:0] seq);
    snap_t s;
    s.req_type = REQ_SNAPSHOT;
    {s.observer_ok, s.source_ready, s.mode_known, s.mode_active, s.value_known} = flags;
    s.raw_value = raw;
    s.seq_num = seq;
    return s;
  endfunction

  task automatic send_item(input snap_t s);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      snap_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    snap_ch.valid <= 1'b1;
    snap_ch.req_type <= s.req_type;
    snap_ch.observer_ok <= s.observer_ok;
    snap_ch.source_ready <= s.source_ready;
    snap_ch.mode_known <= s.mode_known;
    snap_ch.mode_active <= s.mode_active;
    snap_ch.value_known <= s.value_known;
    snap_ch.raw_value <= s.raw_value;
    snap_ch.seq_num <= s.seq_num;
    do @(posedge clk); while (!snap_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_restart();
    snap_t s;
    s.req_type = REQ_RESTART;
    {s.observer_ok, s.source_ready, s.mode_known, s.mode_active, s.value_known} =
      5'($urandom);
    s.raw_value = 16'($urandom);
    s.seq_num = $urandom;
    send_item(s);
    seq_used = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 255));
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    snap_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(input int n_items, input int run_max);
    snap_t           s;
    int              run_left;
    int              pick;
    logic [7:0]      run_val;
    longint unsigned step;
    longint unsigned stale;
    run_left = 0;
    run_val = '0;
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        run_val = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        run_left = $urandom_range(1, run_max);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2 || seq_used > 64'hFFEF_FFFF) begin
        send_restart();
      end else if (pick < 14) begin
        case ($urandom_range(0, 3))
          0: begin
            seq_used++;
            s = make_snap(5'($urandom_range(0, 30)), {8'h00, run_val}, seq_used[31:0]);
          end
          1: begin
            seq_used++;
            s = make_snap(ALL_FLAGS, {8'($urandom_range(1, 255)), 8'($urandom)},
                          seq_used[31:0]);
          end
          2: begin
            stale = (seq_used >= 3) ? seq_used - $urandom_range(0, 3) : 0;
            s = make_snap(ALL_FLAGS, {8'h00, run_val}, stale[31:0]);
          end
          default: begin
            s = make_snap(5'($urandom), 16'($urandom), $urandom);
            if (s.seq_num > seq_used)
              seq_used = s.seq_num;
          end
        endcase
        send_item(s);
      end else begin
        if ($urandom_range(0, 15) == 0)
          step = $urandom_range(1, 1 << 20);
        else
          step = $urandom_range(1, 3);
        seq_used += step;
        run_left--;
        send_item(make_snap(ALL_FLAGS, {8'h00, run_val}, seq_used[31:0]));
      end
    end
  endtask

  initial begin
    logic [9:0]  min_cfg;
    logic [15:0] max_cfg;
    logic [7:0]  cap_val;
    int          run_max;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    snap_ch.valid = 1'b0;
    snap_ch.req_type = 1'b0;
    snap_ch.observer_ok = 1'b0;
    snap_ch.source_ready = 1'b0;
    snap_ch.mode_known = 1'b0;
    snap_ch.mode_active = 1'b0;
    snap_ch.value_known = 1'b0;
    snap_ch.raw_value = '0;
    snap_ch.seq_num = '0;
    idle_on = 1'b0;
    stall_on = 1'b0;
    seq_used = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_on = 1'b1;
    stall_on = 1'b1;
    write_reg(CFG_MIN_STABLE_FRAMES, 16'd1);
    send_item(make_snap(ALL_FLAGS, 16'd0, 32'd1));
    send_item(make_snap(ALL_FLAGS, 16'd0, 32'd2));
    send_item(make_snap(ALL_FLAGS, 16'd255, 32'd3));
    send_item(make_snap(ALL_FLAGS, 16'd256, 32'd4));
    send_item(make_snap(ALL_FLAGS, 16'hFFFF, 32'd5));
    send_item(make_snap(ALL_FLAGS, 16'h8000, 32'd6));
    send_item(make_snap(ALL_FLAGS, 16'h7FFF, 32'd7));
    for (int i = 0; i < 5; i++)
      send_item(make_snap(ALL_FLAGS & ~(5'd1 << i), 16'd10, 32'(8 + i)));
    send_item(make_snap(ALL_FLAGS, 16'd10, 32'd3));
    send_item(make_snap(ALL_FLAGS, 16'd10, 32'd2));
    send_item(make_snap(ALL_FLAGS, 16'd10, 32'hFFFF_FFFF));
    send_item(make_snap(ALL_FLAGS, 16'd11, 32'hFFFF_FFFF));
    send_item(make_snap(ALL_FLAGS, 16'd11, 32'd0));
    send_restart();
    send_item(make_snap(ALL_FLAGS, 16'd10, 32'd0));
    send_item(make_snap(ALL_FLAGS, 16'd0, 32'd1));

    // A count built up under a high threshold stays above a lower one.
    wait_idle();
    write_reg(CFG_MIN_STABLE_FRAMES, 16'd10);
    write_reg(CFG_MAX_REPORTS, 16'd1);
    send_restart();
    for (int i = 1; i <= 10; i++)
      send_item(make_snap(ALL_FLAGS, 16'h005A, 32'(i)));
    for (int i = 11; i <= 20; i++)
      send_item(make_snap(ALL_FLAGS, 16'h00A5, 32'(i)));
    wait_idle();
    write_reg(CFG_MAX_REPORTS, 16'd5);
    write_reg(CFG_MIN_STABLE_FRAMES, 16'd3);
    send_item(make_snap(ALL_FLAGS, 16'h00A5, 32'd21));
    for (int i = 22; i <= 24; i++)
      send_item(make_snap(ALL_FLAGS, 16'h005A, 32'(i)));
    seq_used = 24;

    for (int p = 0; p < 12; p++) begin
      wait_idle();
      idle_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: min_cfg = 10'd0;
        1: min_cfg = 10'd1;
        2: min_cfg = 10'($urandom_range(2, 4));
        3: min_cfg = 10'($urandom_range(5, 8));
        4: min_cfg = 10'd15;
        default: min_cfg = 10'($urandom_range(2, 12));
      endcase
      if (p == 0)
        min_cfg = 10'd0;
      run_max = (min_cfg == 0) ? 17 : int'(min_cfg) + 2;
      case ($urandom_range(0, 7))
        0: max_cfg = 16'd0;
        1, 2: max_cfg = 16'($urandom_range(1, 4));
        3: max_cfg = 16'($urandom_range(5, 40));
        4: max_cfg = 16'($urandom);
        default: max_cfg = 16'hFFFF;
      endcase
      if (p == 1)
        max_cfg = 16'd0;
      write_reg(CFG_MIN_STABLE_FRAMES, {6'($urandom), min_cfg});
      write_reg(CFG_MAX_REPORTS, max_cfg);
      if ($urandom_range(0, 1) == 0)
        send_restart();
      random_phase(30, run_max);
    end

    wait_idle();
    write_reg(CFG_MIN_STABLE_FRAMES, 16'hFFFF);
    write_reg(CFG_MAX_REPORTS, 16'hFFFF);
    send_restart();
    cap_val = 8'($urandom);
    for (int i = 0; i < 602; i++) begin
      seq_used++;
      send_item(make_snap(ALL_FLAGS, {8'h00, cap_val}, seq_used[31:0]));
    end

    wait_idle();
    idle_on = 1'b0;
    stall_on = 1'b0;
    write_reg(CFG_MIN_STABLE_FRAMES, 16'd2);
    write_reg(CFG_MAX_REPORTS, 16'd200);
    send_restart();
    random_phase(100, 4);

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
